@@ src/rfp_pkg.sv @@
package rfp_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DIST_W = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    // Sync byte reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;

    // Byte held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_slot_t;

    // Current sync byte settings
    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
    } sync_cfg_t;

endpackage

@@ src/rfp_in_stage.sv @@
module rfp_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rfp_pkg::BYTE_W-1:0]     s_byte_in,
    output rfp_pkg::byte_slot_t            slot_o,
    input  logic                           pop_i
);

    logic                       valid_reg;
    logic [rfp_pkg::BYTE_W-1:0] data_reg;

    // Take a new byte when the register is empty or drains this cycle
    assign s_ready = !valid_reg || pop_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (pop_i) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload: load on every accepted transaction
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_byte_in;
        end
    end

    assign slot_o.valid = valid_reg;
    assign slot_o.data  = data_reg;

endmodule

@@ src/rfp_frame_fsm.sv @@
module rfp_frame_fsm (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rfp_pkg::byte_slot_t            slot_i,
    output logic                           pop_o,
    input  rfp_pkg::sync_cfg_t             cfg_i,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_frame_done,
    output logic [rfp_pkg::DIST_W-1:0]     m_distance
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_DATA1 = 3'd3,
        PH_DATA2 = 3'd4,
        PH_CHK1  = 3'd5
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [rfp_pkg::DIST_W-1:0] sum_reg, sum_next;
    logic [rfp_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic                       done_reg, done_next;
    logic                       out_valid_reg;
    logic [rfp_pkg::BYTE_W-1:0] b;

    assign b = slot_i.data;

    // Advance one byte when the result register is free or being taken
    assign pop_o = slot_i.valid && (!out_valid_reg || m_ready);

    // Framing step for the byte in the input register
    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        dist_next  = dist_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_HUNT: begin
                if (b == cfg_i.sync_first) begin
                    sum_next   = {{(rfp_pkg::DIST_W-rfp_pkg::BYTE_W){1'b0}}, b};
                    phase_next = PH_SYNC1;
                end
            end
            PH_SYNC1: begin
                // second-sync test wins when both sync values match
                if (b == cfg_i.sync_second) begin
                    sum_next   = sum_reg + {{(rfp_pkg::DIST_W-rfp_pkg::BYTE_W){1'b0}}, b};
                    phase_next = PH_SYNC2;
                end else if (b == cfg_i.sync_first) begin
                    sum_next   = {{(rfp_pkg::DIST_W-rfp_pkg::BYTE_W){1'b0}}, b};
                    phase_next = PH_SYNC1;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_SYNC2: begin
                sum_next   = sum_reg + {{(rfp_pkg::DIST_W-rfp_pkg::BYTE_W){1'b0}}, b};
                dist_next  = {{(rfp_pkg::DIST_W-rfp_pkg::BYTE_W){1'b0}}, b};
                phase_next = PH_DATA1;
            end
            PH_DATA1: begin
                sum_next   = sum_reg + {{(rfp_pkg::DIST_W-rfp_pkg::BYTE_W){1'b0}}, b};
                dist_next  = {dist_reg[rfp_pkg::BYTE_W-1:0], b};
                phase_next = PH_DATA2;
            end
            PH_DATA2: begin
                // drop the frame on a high checksum mismatch
                if (b == sum_reg[rfp_pkg::DIST_W-1:rfp_pkg::BYTE_W]) begin
                    phase_next = PH_CHK1;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_CHK1: begin
                phase_next = PH_HUNT;
                done_next  = (b == sum_reg[rfp_pkg::BYTE_W-1:0]);
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Hold framing state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            sum_reg       <= '0;
            dist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop_o) begin
                phase_reg     <= phase_next;
                sum_reg       <= sum_next;
                dist_reg      <= dist_next;
                done_reg      <= done_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_done = done_reg;
    assign m_distance   = dist_reg;

endmodule

@@ src/range_frame_parser_top.sv @@
// Range frame parser: takes one received byte per input transaction and hunts for six-byte
// distance frames (first sync, second sync, distance high, distance low, checksum high,
// checksum low; checksum is the 16-bit wrapping sum of the four leading bytes). Every byte
// gives exactly one result: frame_done is set when the byte closed a frame with a matching
// checksum, and distance carries the current (possibly partly assembled) distance. Throughput
// is one byte per clock while m_ready is held high; the input register and the result
// register lie around the combinational framing step. s_ready depends combinationally on m_ready
// through the result register's load condition. The sync byte values are written through the
// cfg port (index 0: first sync, reset 0xA5; index 1: second sync, reset 0x5A) and take
// effect on the next byte processed; write them only while no bytes are in flight.
module range_frame_parser_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rfp_pkg::BYTE_W-1:0]        s_byte_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_frame_done,
    output logic [rfp_pkg::DIST_W-1:0]        m_distance,
    input  logic                              cfg_we,
    input  logic [rfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rfp_pkg::BYTE_W-1:0]        cfg_wdata
);

    rfp_pkg::byte_slot_t slot;
    rfp_pkg::sync_cfg_t  sync_cfg_reg;
    logic                pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_cfg_reg.sync_first  <= rfp_pkg::SYNC_FIRST_RST;
            sync_cfg_reg.sync_second <= rfp_pkg::SYNC_SECOND_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                rfp_pkg::CFG_SYNC_FIRST:  sync_cfg_reg.sync_first  <= cfg_wdata;
                rfp_pkg::CFG_SYNC_SECOND: sync_cfg_reg.sync_second <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rfp_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .slot_o    (slot),
        .pop_i     (pop)
    );

    rfp_frame_fsm u_frame_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .slot_i       (slot),
        .pop_o        (pop),
        .cfg_i        (sync_cfg_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_done (m_frame_done),
        .m_distance   (m_distance)
    );

endmodule

@@ src/rfp_checker.sv @@
module rfp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_frame_done,
    input logic [rfp_pkg::DIST_W-1:0]    m_distance
);

    logic prev_done_reg;

    // Track whether the last delivered transaction closed a frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_done_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            prev_done_reg <= m_frame_done;
        end
    end

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_frame_done) && $stable(m_distance))
        else $error("result payload changed while stalled");

    // No result comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A free output side never stalls the input
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output ready");

    // Each frame needs six bytes, so completions never come back to back
    a_done_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_frame_done |-> !prev_done_reg)
        else $error("frame completions on consecutive results");

endmodule

bind range_frame_parser_top rfp_checker u_rfp_checker (.*);
